FILE: sv/nsbh_pkg.sv
`default_nettype none
package nsbh_pkg;

    localparam int QW = 24;
    localparam int CFG_W = 23;
    localparam int CFG_IDX_W = 2;
    localparam int DEF_MAX_BOXES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BOXES = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic signed [QW-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [QW-1:0] Q_MIN = -24'sh800000;

    typedef struct packed {
        logic                 kind;
        logic [2:0]           slot;
        logic signed [QW-1:0] box_x;
        logic signed [QW-1:0] box_y;
        logic signed [QW-1:0] start_x;
        logic signed [QW-1:0] start_y;
        logic signed [QW-1:0] stop_x;
        logic signed [QW-1:0] stop_y;
    } item_t;

    typedef struct packed {
        logic signed [QW-1:0] hit_x;
        logic signed [QW-1:0] hit_y;
        logic                 hit_found;
    } result_t;

    // one obstacle centre as it travels along the cell row
    typedef struct packed {
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
    } centre_t;

endpackage
`default_nettype wire

FILE: sv/nsbh_cell.sv
`default_nettype none
// One slot of the obstacle table; during a query the centres rotate one
// cell per shift toward cell 0.
module nsbh_cell
    import nsbh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    load,
    input  wire centre_t load_data,
    input  wire logic    shift,
    input  wire centre_t from_next,
    output centre_t      held
);
    centre_t held_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= load_data;
        end
        else if (shift)
        begin
            held_reg <= from_next;
        end
    end

    assign held = held_reg;
endmodule
`default_nettype wire

FILE: sv/nsbh_div.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle: quo = num / den, unsigned.
module nsbh_div
    import nsbh_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 50
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          go,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    assign trial = {rem_reg[DW-1:0], quo_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && !go && cnt_reg == CW'(1);
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

FILE: sv/nsbh_edge.sv
`default_nettype none
// Edge test and nearest-hit keeper. One edge per pass of a small sequencer:
// products, hit test, divide for the free coordinate, round, distance, keep.
module nsbh_edge
    import nsbh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              clear,
    input  wire logic              go,
    input  wire logic signed [26:0] ax,
    input  wire logic signed [26:0] ay,
    input  wire logic signed [26:0] bx,
    input  wire logic signed [26:0] by,
    input  wire logic signed [QW-1:0] sx,
    input  wire logic signed [QW-1:0] sy,
    input  wire logic signed [QW-1:0] ex,
    input  wire logic signed [QW-1:0] ey,
    output logic                   done,
    output result_t                best
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_NUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_KEEP = 3'd5;

    logic [2:0] state_reg, state_next;

    // doubled-unit geometry, 26..28 bits
    logic signed [27:0] d1x, d1y, d2x, d2y, wx, wy;
    logic signed [56:0] den_reg, na_reg, nb_reg;
    logic               vert_reg;
    logic signed [26:0] fix_reg;      // edge coordinate, doubled
    logic signed [QW:0] fixq_reg;     // edge coordinate rounded to Q15.8
    logic signed [60:0] num_reg;
    logic signed [29:0] dd_reg;
    logic               neg_reg;
    logic               dgo;
    logic               ddone;
    logic [63:0]        quo;
    logic signed [QW-1:0] ix_reg, iy_reg;
    logic [49:0]        dist_reg, best_reg;
    logic               found_reg;
    logic signed [QW-1:0] hx_reg, hy_reg;
    logic signed [QW:0] dxs, dys;
    logic signed [QW+1:0] qrnd;
    logic signed [QW+1:0] free;

    assign d1x = 28'(2 * 28'(ex)) - 28'(2 * 28'(sx));
    assign d1y = 28'(2 * 28'(ey)) - 28'(2 * 28'(sy));
    assign d2x = 28'(bx) - 28'(ax);
    assign d2y = 28'(by) - 28'(ay);
    assign wx  = 28'(2 * 28'(sx)) - 28'(ax);
    assign wy  = 28'(2 * 28'(sy)) - 28'(ay);

    // rdiv(a,2) for the fixed coordinate: (|a|+1)>>1 with sign
    function automatic logic signed [QW:0] half_round(input logic signed [26:0] a);
        logic [26:0] m;
        logic [26:0] r;
        begin
            m = a[26] ? 27'(-a) : 27'(a);
            r = (m + 27'd1) >> 1;
            half_round = a[26] ? -(QW+1)'(r) : (QW+1)'(r);
        end
    endfunction

    function automatic logic signed [QW-1:0] sat(input logic signed [QW+1:0] v);
        begin
            if (v > (QW+2)'(Q_MAX))
            begin
                sat = Q_MAX;
            end
            else if (v < (QW+2)'(Q_MIN))
            begin
                sat = Q_MIN;
            end
            else
            begin
                sat = v[QW-1:0];
            end
        end
    endfunction

    logic [60:0] num_abs;
    logic [29:0] dd_abs;
    assign num_abs = num_reg[60] ? 61'(-num_reg) : 61'(num_reg);
    assign dd_abs  = dd_reg[29] ? 30'(-dd_reg) : 30'(dd_reg);

    nsbh_div #(.NW(64), .DW(32)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (dgo),
        .num  (64'({num_abs, 1'b0}) + 64'(dd_abs)),
        .den  ({1'b0, dd_abs, 1'b0}),
        .done (ddone),
        .quo  (quo)
    );

    // quotient fits comfortably; clip before sign to saturate
    logic [QW+1:0] qclip;
    assign qclip = (quo > 64'(1 << QW)) ? (QW+2)'(1 << QW) : quo[QW+1:0];
    assign qrnd  = (neg_reg ^ dd_reg[29]) ? -$signed(qclip) : $signed(qclip);
    assign free  = qrnd;

    assign dgo = (state_reg == S_NUM);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (go) state_next = S_TEST;
            S_TEST:
            begin
                if (den_reg == 0 || na_reg < 0 || na_reg > den_reg
                    || nb_reg < 0 || nb_reg > den_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_NUM;
                end
            end
            S_NUM:  state_next = S_DIV;
            S_DIV:  if (ddone) state_next = S_SQ;
            S_SQ:   state_next = S_KEEP;
            S_KEEP: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign done = (state_reg == S_KEEP)
        || (state_reg == S_TEST && state_next == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                found_reg <= 1'b0;
            end
            else if (state_reg == S_KEEP && (!found_reg || dist_reg < best_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    logic signed [56:0] na_raw, nb_raw, den_raw;
    assign den_raw = 57'(d2y * d1x) - 57'(d2x * d1y);
    assign na_raw  = 57'(d2x * wy) - 57'(d2y * wx);
    assign nb_raw  = 57'(d1x * wy) - 57'(d1y * wx);

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            hx_reg <= '0;
            hy_reg <= '0;
            best_reg <= '0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    den_reg  <= den_raw[56] ? -den_raw : den_raw;
                    na_reg   <= den_raw[56] ? -na_raw : na_raw;
                    nb_reg   <= den_raw[56] ? -nb_raw : nb_raw;
                    vert_reg <= (d2x == 0);
                    fix_reg  <= (d2x == 0) ? ax : ay;
                end
            end
            S_TEST:
            begin
                fixq_reg <= half_round(fix_reg);
                if (vert_reg)
                begin
                    num_reg <= 61'(2 * 61'(sy) * 61'(d1x))
                        + 61'(61'(d1y) * 61'(fix_reg - 27'(2 * 27'(sx))));
                    dd_reg  <= 30'(2 * 30'(d1x));
                end
                else
                begin
                    num_reg <= 61'(2 * 61'(sx) * 61'(d1y))
                        + 61'(61'(d1x) * 61'(fix_reg - 27'(2 * 27'(sy))));
                    dd_reg  <= 30'(2 * 30'(d1y));
                end
            end
            S_NUM:
            begin
                neg_reg <= num_reg[60];
            end
            S_DIV:
            begin
                if (ddone)
                begin
                    if (vert_reg)
                    begin
                        ix_reg <= sat((QW+2)'(fixq_reg));
                        iy_reg <= sat(free);
                    end
                    else
                    begin
                        iy_reg <= sat((QW+2)'(fixq_reg));
                        ix_reg <= sat(free);
                    end
                end
            end
            S_SQ:
            begin
                dist_reg <= 50'(dxs * dxs) + 50'(dys * dys);
            end
            S_KEEP:
            begin
                if (!found_reg || dist_reg < best_reg)
                begin
                    best_reg <= dist_reg;
                    hx_reg   <= ix_reg;
                    hy_reg   <= iy_reg;
                end
            end
            default: ;
        endcase
    end

    assign dxs = (QW+1)'(ix_reg) - (QW+1)'(sx);
    assign dys = (QW+1)'(iy_reg) - (QW+1)'(sy);

    assign best.hit_x     = hx_reg;
    assign best.hit_y     = hy_reg;
    assign best.hit_found = found_reg;
endmodule
`default_nettype wire

FILE: sv/nearest_segment_box_hit_top.sv
`default_nettype none
// Load item: no result, busy stays low. Query: a missed edge ends at the hit test, a hit
// edge also runs the 64-step divider, over 4*(min(active_boxes, MAX_BOXES)+1) edges;
// done is high for one cycle right after the last edge. The receiver cannot stall.
// One item at a time; after a query over n boxes with 0 < n < MAX_BOXES, busy stays
// high past the last edge while the row rotates back to slot order.
// Reset clears control and sets the config registers to their defaults; the table content is undefined until loaded.
module nearest_segment_box_hit_top
    import nsbh_pkg::*;
#(
    parameter int MAX_BOXES = DEF_MAX_BOXES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire item_t                in_item,
    output logic                      done,
    output result_t                   out_item,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);
    localparam int NW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES + 1) : 1;

    logic [CFG_W-1:0] box_size_reg, floor_width_reg, floor_height_reg;
    logic [3:0]       active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_size_reg     <= 23'd10240;
            floor_width_reg  <= 23'd262144;
            floor_height_reg <= 23'd196608;
            active_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOX_SIZE:     box_size_reg     <= cfg_data;
                REG_FLOOR_WIDTH:  floor_width_reg  <= cfg_data;
                REG_FLOOR_HEIGHT: floor_height_reg <= cfg_data;
                REG_ACTIVE_BOXES: active_reg       <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // query registers
    logic signed [QW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                 run_reg;
    logic [NW-1:0]        left_reg;     // rectangles still to visit, floor last
    logic [1:0]           side_reg;
    logic                 wait_reg;
    logic                 done_reg;
    logic                 egi;
    logic                 edone;
    result_t              best;

    // cell row: cell 0 feeds the edge unit
    centre_t cells [MAX_BOXES];
    logic accept;
    logic shift;
    logic fix_shift;
    assign accept = start && !busy;

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            nsbh_cell u_cell (
                .clk      (clk),
                .load     (accept && in_item.kind == KIND_LOAD
                           && 32'(in_item.slot) == g),
                .load_data({in_item.box_x, in_item.box_y}),
                .shift    (shift),
                .from_next(cells[(g + 1) % MAX_BOXES]),
                .held     (cells[g])
            );
        end
    endgenerate

    logic [NW-1:0] nbox;
    assign nbox = (32'(active_reg) > MAX_BOXES) ? NW'(MAX_BOXES) : NW'(active_reg);

    // advance one edge at a time; shift the row after the last edge of each box,
    // and keep shifting after the query until the row is back in slot order
    assign shift = (run_reg && edone && side_reg == 2'd3 && left_reg != NW'(0))
        || fix_shift;

    logic signed [26:0] x0, y0, x1, y1, ax, ay, bx, by;
    always_comb
    begin
        if (left_reg == NW'(0))
        begin
            x0 = '0;
            y0 = '0;
            x1 = 27'(2 * 27'(floor_width_reg));
            y1 = 27'(2 * 27'(floor_height_reg));
        end
        else
        begin
            x0 = 27'(2 * 27'(cells[0].x)) - 27'(box_size_reg);
            y0 = 27'(2 * 27'(cells[0].y)) - 27'(box_size_reg);
            x1 = 27'(2 * 27'(cells[0].x)) + 27'(box_size_reg);
            y1 = 27'(2 * 27'(cells[0].y)) + 27'(box_size_reg);
        end
        case (side_reg)
            2'd0:
            begin
                ax = x0;
                ay = y0;
                bx = x1;
                by = y0;
            end
            2'd1:
            begin
                ax = x1;
                ay = y0;
                bx = x1;
                by = y1;
            end
            2'd2:
            begin
                ax = x1;
                ay = y1;
                bx = x0;
                by = y1;
            end
            default:
            begin
                ax = x0;
                ay = y1;
                bx = x0;
                by = y0;
            end
        endcase
    end

    assign egi = run_reg && !wait_reg;

    nsbh_edge u_edge (
        .clk  (clk),
        .rst_n(rst_n),
        .clear(accept && in_item.kind == KIND_QUERY),
        .go   (egi),
        .ax   (ax), .ay(ay), .bx(bx), .by(by),
        .sx   (sx_reg), .sy(sy_reg), .ex(ex_reg), .ey(ey_reg),
        .done (edone),
        .best (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            wait_reg <= 1'b0;
            done_reg <= 1'b0;
            side_reg <= '0;
            left_reg <= '0;
        end
        else
        begin
            // strobe the result right after the floor's last edge
            done_reg <= run_reg && edone && side_reg == 2'd3 && left_reg == NW'(0);
            if (accept && in_item.kind == KIND_QUERY)
            begin
                run_reg  <= 1'b1;
                wait_reg <= 1'b0;
                side_reg <= '0;
                left_reg <= nbox;
            end
            else if (run_reg)
            begin
                if (egi)
                begin
                    wait_reg <= 1'b1;
                end
                else if (edone)
                begin
                    wait_reg <= 1'b0;
                    side_reg <= side_reg + 2'd1;
                    if (side_reg == 2'd3)
                    begin
                        if (left_reg == NW'(0))
                        begin
                            run_reg <= 1'b0;
                        end
                        else
                        begin
                            left_reg <= left_reg - 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_item.kind == KIND_QUERY)
        begin
            sx_reg <= in_item.start_x;
            sy_reg <= in_item.start_y;
            ex_reg <= in_item.stop_x;
            ey_reg <= in_item.stop_y;
        end
    end

    // rotation leaves the row shifted by nbox; rotate back is unnecessary only
    // when nbox is 0 or MAX_BOXES, so hold the busy flag until re-aligned
    logic [NW-1:0] rot_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else if (accept && in_item.kind == KIND_QUERY)
        begin
            rot_reg <= NW'(MAX_BOXES) - nbox;
        end
        else if (fix_shift)
        begin
            rot_reg <= rot_reg - 1'b1;
        end
    end

    // finishing rotation reuses the shift path
    assign fix_shift = !run_reg && rot_reg != NW'(0) && rot_reg != NW'(MAX_BOXES);

    assign busy = run_reg || done_reg || fix_shift;
    assign done = done_reg;
    assign out_item = best;
endmodule
`default_nettype wire
